// File: hdl/csync_pkg.sv
// csync_pkg: shared types and codes of the csync rdata type bitmap parser
package csync_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TYPE   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SHORT   = 2'd1;
  localparam logic [1:0] ERR_TOOLONG = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] type_code;
    logic [31:0] serial_number;
    logic [15:0] flag_bits;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic [7:0] bits;
    logic [7:0] window;
    logic [4:0] index;
    logic       mark_pend;
    logic [1:0] mark_kind;
    logic [1:0] mark_err;
  } bmap_load_t;

endpackage

// File: hdl/csync_bmap_ser.sv
// csync_bmap_ser: bit-serial expansion of one bitmap byte into type codes, plus an optional closing marker
module csync_bmap_ser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csync_pkg::bmap_load_t  ld,
  input  logic                   adv,
  output logic                   busy,
  output logic                   emit,
  output csync_pkg::out_word_t   res
);
  import csync_pkg::*;

  logic [7:0] bits_r, bits_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] win_r;
  logic [4:0] idx_r;
  logic       mark_pend_r, mark_pend_nxt;
  logic [1:0] mark_kind_r;
  logic [1:0] mark_err_r;

  assign busy = (bits_r != 8'd0) || mark_pend_r;

  always_comb begin
    bits_nxt      = bits_r;
    pos_nxt       = pos_r;
    mark_pend_nxt = mark_pend_r;
    emit          = 1'b0;
    res           = '0;
    if (adv) begin
      priority if (bits_r != 8'd0) begin
        bits_nxt = {bits_r[6:0], 1'b0};
        pos_nxt  = pos_r + 3'd1;
        if (bits_r[7]) begin
          emit              = 1'b1;
          res.item_kind     = KIND_TYPE;
          res.type_code     = {win_r, idx_r, pos_r};
          res.last_of_run   = (bits_r[6:0] == 7'd0) && !mark_pend_r;
        end
      end else if (mark_pend_r) begin
        mark_pend_nxt   = 1'b0;
        emit            = 1'b1;
        res.item_kind   = mark_kind_r;
        res.error_code  = mark_err_r;
        res.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= 8'd0;
      mark_pend_r <= 1'b0;
      pos_r       <= 3'd0;
    end else if (ld.load) begin
      bits_r      <= ld.bits;
      mark_pend_r <= ld.mark_pend;
      pos_r       <= 3'd0;
    end else begin
      bits_r      <= bits_nxt;
      mark_pend_r <= mark_pend_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      win_r       <= ld.window;
      idx_r       <= ld.index;
      mark_kind_r <= ld.mark_kind;
      mark_err_r  <= ld.mark_err;
    end
  end

endmodule

// File: hdl/csync_rdata_type_bitmap_parser_core.sv
// csync_rdata_type_bitmap_parser_core: top level of the csync rdata type bitmap parser
// header, window and length words are parsed as they are accepted; any result is in out_word next cycle
// a bitmap word is loaded into the bit-serial scanner, which walks its bits up to its last set bit,
// then emits a closing marker if the word ended the record; in_stall holds while the scan is busy
// the bitmap word is scanned msb first, one bit per cycle while out_stall allows, by a shift register
// rst_n is synchronous: parse state returns to the header phase and out_valid drops
module csync_rdata_type_bitmap_parser_core #(
  parameter int MAX_BLOCK_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  csync_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output csync_pkg::out_word_t  out_word
);
  import csync_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_WINDOW = 3'd1;
  localparam logic [2:0] PH_LENGTH = 3'd2;
  localparam logic [2:0] PH_BITMAP = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  localparam logic [7:0] MaxBlock = 8'(MAX_BLOCK_BYTES);

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] serial_r, serial_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [7:0]  win_r, win_nxt;
  logic [5:0]  brem_r, brem_nxt;
  logic [4:0]  bidx_r, bidx_nxt;

  logic        out_valid_r;
  out_word_t   out_word_r;

  logic        adv;
  logic        accept;
  logic        direct_emit;
  out_word_t   direct_res;
  bmap_load_t  ld;
  logic        ser_busy;
  logic        ser_emit;
  out_word_t   ser_res;
  logic [7:0]  b;
  logic        eor;
  logic [5:0]  brem_dec;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = ser_busy || !adv;
  assign accept   = in_valid && !in_stall;
  assign b        = in_word.data_byte;
  assign eor      = in_word.end_of_record;
  assign brem_dec = brem_r - 6'd1;

  // parse step for one accepted word
  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    serial_nxt  = serial_r;
    flags_nxt   = flags_r;
    win_nxt     = win_r;
    brem_nxt    = brem_r;
    bidx_nxt    = bidx_r;
    direct_emit = 1'b0;
    direct_res  = '0;
    ld          = '0;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hcnt_r < 3'd4) begin
            serial_nxt = {serial_r[23:0], b};
          end else begin
            flags_nxt = {flags_r[7:0], b};
          end
          priority if (eor) begin
            direct_emit           = 1'b1;
            direct_res.item_kind  = KIND_REJECT;
            direct_res.error_code = ERR_SHORT;
          end else if (hcnt_r >= 3'd5) begin
            direct_emit              = 1'b1;
            direct_res.item_kind     = KIND_HEADER;
            direct_res.serial_number = serial_nxt;
            direct_res.flag_bits     = flags_nxt;
            hcnt_nxt                 = 3'd0;
            phase_nxt                = PH_WINDOW;
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
        PH_WINDOW: begin
          win_nxt = b;
          if (eor) begin
            direct_emit          = 1'b1;
            direct_res.item_kind = KIND_ACCEPT;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          priority if (b > MaxBlock) begin
            if (eor) begin
              direct_emit           = 1'b1;
              direct_res.item_kind  = KIND_REJECT;
              direct_res.error_code = ERR_TOOLONG;
            end else begin
              phase_nxt = PH_ERROR;
            end
          end else if (b == 8'd0) begin
            if (eor) begin
              direct_emit          = 1'b1;
              direct_res.item_kind = KIND_ACCEPT;
            end else begin
              phase_nxt = PH_WINDOW;
            end
          end else begin
            brem_nxt = b[5:0];
            bidx_nxt = 5'd0;
            if (eor) begin
              direct_emit           = 1'b1;
              direct_res.item_kind  = KIND_REJECT;
              direct_res.error_code = ERR_OVERRUN;
            end else begin
              phase_nxt = PH_BITMAP;
            end
          end
        end
        PH_BITMAP: begin
          ld.load   = 1'b1;
          ld.bits   = b;
          ld.window = win_r;
          ld.index  = bidx_r;
          brem_nxt  = brem_dec;
          bidx_nxt  = bidx_r + 5'd1;
          if (brem_dec == 6'd0) begin
            phase_nxt    = PH_WINDOW;
            ld.mark_pend = eor;
            ld.mark_kind = KIND_ACCEPT;
            ld.mark_err  = ERR_NONE;
          end else begin
            ld.mark_pend = eor;
            ld.mark_kind = KIND_REJECT;
            ld.mark_err  = ERR_OVERRUN;
          end
        end
        default: begin
          if (eor) begin
            direct_emit           = 1'b1;
            direct_res.item_kind  = KIND_REJECT;
            direct_res.error_code = ERR_TOOLONG;
          end
        end
      endcase
      direct_res.last_of_run = 1'b1;
      if (eor) begin
        phase_nxt  = PH_HEADER;
        hcnt_nxt   = 3'd0;
        serial_nxt = 32'd0;
        flags_nxt  = 16'd0;
        win_nxt    = 8'd0;
        brem_nxt   = 6'd0;
        bidx_nxt   = 5'd0;
      end
    end
  end

  csync_bmap_ser u_ser (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (ld),
    .adv   (adv),
    .busy  (ser_busy),
    .emit  (ser_emit),
    .res   (ser_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcnt_r   <= 3'd0;
      serial_r <= 32'd0;
      flags_r  <= 16'd0;
      win_r    <= 8'd0;
      brem_r   <= 6'd0;
      bidx_r   <= 5'd0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      serial_r <= serial_nxt;
      flags_r  <= flags_nxt;
      win_r    <= win_nxt;
      brem_r   <= brem_nxt;
      bidx_r   <= bidx_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= direct_emit || ser_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= ser_emit ? ser_res : direct_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_accept_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    ser_busy |-> in_stall)
    else $error("word accepted while bitmap scan in progress");

  a_end_resets_parse: assert property (@(posedge clk) disable iff (!rst_n)
    accept && eor |=> phase_r == PH_HEADER && hcnt_r == 3'd0)
    else $error("parse state not cleared after end of record");

  a_header_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.item_kind == KIND_HEADER |-> out_word_r.last_of_run)
    else $error("header result not marked last");

  a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(direct_emit && ser_emit))
    else $error("two results in one cycle");

endmodule

// File: bench/tb.sv
// tb: self-checking bench for the csync rdata type bitmap parser core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csync_pkg::*;

  localparam int MAX_BLOCK    = 32;
  localparam int RANDOM_WORDS = 180;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum logic [2:0] {
    PH_HEADER, PH_WINDOW, PH_LENGTH, PH_BITMAP, PH_SKIP
  } parse_phase_e;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  csync_rdata_type_bitmap_parser_core #(.MAX_BLOCK_BYTES(MAX_BLOCK)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // predictor state
  parse_phase_e phase;
  logic [2:0]   hdr_count;
  logic [31:0]  serial_acc;
  logic [15:0]  flags_acc;
  logic [7:0]   window;
  logic [5:0]   blk_left;
  logic [4:0]   blk_index;

  out_word_t   csync_results[$];
  in_word_t    record_words[$];
  logic [7:0]  rec_bytes[$];
  int          errors     = 0;
  int          cycles     = 0;
  logic        in_fire    = 1'b0;
  int          gap_left   = 0;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  function automatic out_word_t mk_result(logic [1:0] kind, logic [15:0] code,
                                          logic [31:0] serial, logic [15:0] flags,
                                          logic [1:0] err);
    out_word_t r;
    r.item_kind     = kind;
    r.type_code     = code;
    r.serial_number = serial;
    r.flag_bits     = flags;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic void clear_parse();
    phase      = PH_HEADER;
    hdr_count  = '0;
    serial_acc = '0;
    flags_acc  = '0;
    window     = '0;
    blk_left   = '0;
    blk_index  = '0;
  endfunction

  function automatic void predict_word(in_word_t w);
    out_word_t  run[$];
    out_word_t  last;
    logic [7:0] b;
    logic       fin;
    int         k;
    b   = w.data_byte;
    fin = w.end_of_record;
    case (phase)
      PH_HEADER: begin
        if (hdr_count < 3'd4) serial_acc = {serial_acc[23:0], b};
        else flags_acc = {flags_acc[7:0], b};
        if (fin) begin
          run.push_back(mk_result(KIND_REJECT, '0, '0, '0, ERR_SHORT));
        end else if (hdr_count >= 3'd5) begin
          run.push_back(mk_result(KIND_HEADER, '0, serial_acc, flags_acc, ERR_NONE));
          hdr_count = '0;
          phase = PH_WINDOW;
        end else begin
          hdr_count = hdr_count + 3'd1;
        end
      end
      PH_WINDOW: begin
        window = b;
        if (fin) run.push_back(mk_result(KIND_ACCEPT, '0, '0, '0, ERR_NONE));
        else phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (b > MAX_BLOCK) begin
          if (fin) run.push_back(mk_result(KIND_REJECT, '0, '0, '0, ERR_TOOLONG));
          else phase = PH_SKIP;
        end else if (b == 8'd0) begin
          if (fin) run.push_back(mk_result(KIND_ACCEPT, '0, '0, '0, ERR_NONE));
          else phase = PH_WINDOW;
        end else begin
          blk_left  = b[5:0];
          blk_index = '0;
          if (fin) run.push_back(mk_result(KIND_REJECT, '0, '0, '0, ERR_OVERRUN));
          else phase = PH_BITMAP;
        end
      end
      PH_BITMAP: begin
        // msb is the lowest type of the byte
        for (k = 0; k < 8; k++) begin
          if (b[7-k])
            run.push_back(mk_result(KIND_TYPE, {window, blk_index, 3'(k)}, '0, '0,
                                    ERR_NONE));
        end
        blk_left  = blk_left - 6'd1;
        blk_index = blk_index + 5'd1;
        if (blk_left == 6'd0) begin
          phase = PH_WINDOW;
          if (fin) run.push_back(mk_result(KIND_ACCEPT, '0, '0, '0, ERR_NONE));
        end else if (fin) begin
          run.push_back(mk_result(KIND_REJECT, '0, '0, '0, ERR_OVERRUN));
        end
      end
      default: begin
        if (fin) run.push_back(mk_result(KIND_REJECT, '0, '0, '0, ERR_TOOLONG));
      end
    endcase
    if (fin) clear_parse();
    if (run.size() > 0) begin
      last = run.pop_back();
      last.last_of_run = 1'b1;
      run.push_back(last);
    end
    foreach (run[i]) csync_results.push_back(run[i]);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(out_word_t got);
    out_word_t want;
    if (csync_results.size() == 0) begin
      $error("result word with none expected: item_kind %0d", got.item_kind);
      errors++;
      return;
    end
    want = csync_results.pop_front();
    compare_field("item_kind", want.item_kind, got.item_kind);
    compare_field("type_code", want.type_code, got.type_code);
    compare_field("serial_number", want.serial_number, got.serial_number);
    compare_field("flag_bits", want.flag_bits, got.flag_bits);
    compare_field("error_code", want.error_code, got.error_code);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction

  function automatic void queue_record();
    in_word_t w;
    foreach (rec_bytes[i]) begin
      w.data_byte     = rec_bytes[i];
      w.end_of_record = (i == rec_bytes.size() - 1);
      record_words.push_back(w);
    end
    rec_bytes.delete();
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int block_len();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return MAX_BLOCK;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (!rst_n) begin
      clear_parse();
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_word(in_word);
      if (out_valid && !out_stall) check_result(out_word);
    end
  end

  // driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end
      if (gap_left > 0 || record_words.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_word  <= record_words.pop_front();
        in_valid <= 1'b1;
        burst_left--;
      end
    end
  end

  // result stall pattern
  always @(negedge clk) begin
    if (cycles % 97 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (cycles % 7) >= 4;
    endcase
  end

  initial begin
    int start;
    int pick;
    int blk;
    int groups;
    clear_parse();

    // end mark inside the header
    rec_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    queue_record();
    // full bitmap byte with the end mark
    rec_bytes = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hFF, 8'h01, 8'hFF};
    queue_record();
    // zero-length block then a lone trailing byte
    rec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
    queue_record();
    // empty bitmap byte, then the end mark inside the block
    rec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h20, 8'h00, 8'h01};
    queue_record();
    // block too long, trailing word ignored
    rec_bytes = '{8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h00, 8'h21, 8'h7E};
    queue_record();

    start = record_words.size();
    while (record_words.size() - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) rec_bytes.push_back(any_byte());
      end else begin
        repeat (6) rec_bytes.push_back(any_byte());
        groups = $urandom_range(0, 3);
        repeat (groups) begin
          rec_bytes.push_back(any_byte());
          blk = block_len();
          rec_bytes.push_back(8'(blk));
          repeat (blk) rec_bytes.push_back(any_byte());
        end
        case (pick)
          1: begin
            rec_bytes.push_back(any_byte());
            rec_bytes.push_back(8'($urandom_range(MAX_BLOCK + 1, 255)));
            repeat ($urandom_range(0, 3)) rec_bytes.push_back(any_byte());
          end
          2: begin
            rec_bytes.push_back(any_byte());
            blk = $urandom_range(1, 6);
            rec_bytes.push_back(8'(blk));
            repeat ($urandom_range(0, blk - 1)) rec_bytes.push_back(any_byte());
          end
          3: rec_bytes.push_back(any_byte());
          default: begin
            rec_bytes.push_back(any_byte());
            blk = block_len();
            rec_bytes.push_back(8'(blk));
            repeat (blk) rec_bytes.push_back(any_byte());
          end
        endcase
      end
      queue_record();
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (record_words.size() != 0 || in_valid) @(posedge clk);
    while (csync_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
